>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define KBD_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("%m: invariant violated");

// Check that a trigger implies a condition in the next cycle.
`define KBD_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("%m: follow-up check violated");

`endif

>>> hw/rtl/kbd_dec_pkg.sv
// Shared types, constants and scan code tables for the keyboard decoder.
// No dependencies; used by every RTL module of the block.
package kbd_dec_pkg;

    // Queue geometry: holds QUEUE_SLOTS-1 characters.
    localparam int QUEUE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
    localparam int FILL_OUT_W  = 8;

    // Scan codes with special meaning.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_LCTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_LCTRL_BREAK  = 8'h9D;
    localparam int         SC_BREAK_BIT    = 7;

    localparam logic [7:0] CHAR_UNDEF     = 8'hFF;
    localparam logic [7:0] CHAR_CTRL_BITS = 8'h1F;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_POP  = 1'b1
    } kbd_op_t;

    typedef struct packed {
        kbd_op_t    opcode;
        logic [7:0] scan_byte;
    } kbd_in_t;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_char;
        logic       key_dropped;
        logic       pop_valid;
        logic [7:0] pop_char;
        logic [7:0] queue_count;
    } kbd_out_t;

    // Translated key from the decoder.
    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } kbd_key_t;

    // Requests into the character queue.
    typedef struct packed {
        logic       push;
        logic [7:0] push_char;
        logic       pop;
    } kbd_q_req_t;

    // Queue status before the current request, plus fill after it.
    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FILL_OUT_W-1:0] fill_next;
    } kbd_q_stat_t;

    // Unshifted Set 1 make-code table.
    function automatic logic [7:0] plain_map(input logic [6:0] code);
        logic [7:0] ch;
        unique case (code)
            7'd1:  ch = 8'h1B;
            7'd2:  ch = 8'h31;
            7'd3:  ch = 8'h32;
            7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;
            7'd6:  ch = 8'h35;
            7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;
            7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;
            7'd12: ch = 8'h2D;
            7'd13: ch = 8'h3D;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h71;
            7'd17: ch = 8'h77;
            7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;
            7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;
            7'd22: ch = 8'h75;
            7'd23: ch = 8'h69;
            7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;
            7'd26: ch = 8'h5B;
            7'd27: ch = 8'h5D;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h61;
            7'd31: ch = 8'h73;
            7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;
            7'd35: ch = 8'h68;
            7'd36: ch = 8'h6A;
            7'd37: ch = 8'h6B;
            7'd38: ch = 8'h6C;
            7'd39: ch = 8'h3B;
            7'd40: ch = 8'h27;
            7'd41: ch = 8'h60;
            7'd43: ch = 8'h5C;
            7'd44: ch = 8'h7A;
            7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;
            7'd48: ch = 8'h62;
            7'd49: ch = 8'h6E;
            7'd50: ch = 8'h6D;
            7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;
            7'd53: ch = 8'h2F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd71: ch = 8'h37;
            7'd72: ch = 8'h38;
            7'd73: ch = 8'h39;
            7'd74: ch = 8'h2D;
            7'd75: ch = 8'h34;
            7'd76: ch = 8'h35;
            7'd77: ch = 8'h36;
            7'd78: ch = 8'h2B;
            7'd79: ch = 8'h31;
            7'd80: ch = 8'h32;
            7'd81: ch = 8'h33;
            7'd82: ch = 8'h30;
            7'd83: ch = 8'h2E;
            default: ch = CHAR_UNDEF;
        endcase
        return ch;
    endfunction

    // Shifted Set 1 make-code table.
    function automatic logic [7:0] upper_map(input logic [6:0] code);
        logic [7:0] ch;
        unique case (code)
            7'd1:  ch = 8'h1B;
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h40;
            7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h24;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5E;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2A;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5F;
            7'd13: ch = 8'h2B;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h51;
            7'd17: ch = 8'h57;
            7'd18: ch = 8'h45;
            7'd19: ch = 8'h52;
            7'd20: ch = 8'h54;
            7'd21: ch = 8'h59;
            7'd22: ch = 8'h55;
            7'd23: ch = 8'h49;
            7'd24: ch = 8'h4F;
            7'd25: ch = 8'h50;
            7'd26: ch = 8'h7B;
            7'd27: ch = 8'h7D;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h41;
            7'd31: ch = 8'h53;
            7'd32: ch = 8'h44;
            7'd33: ch = 8'h46;
            7'd34: ch = 8'h47;
            7'd35: ch = 8'h48;
            7'd36: ch = 8'h4A;
            7'd37: ch = 8'h4B;
            7'd38: ch = 8'h4C;
            7'd39: ch = 8'h3A;
            7'd40: ch = 8'h22;
            7'd41: ch = 8'h7E;
            7'd43: ch = 8'h7C;
            7'd44: ch = 8'h5A;
            7'd45: ch = 8'h58;
            7'd46: ch = 8'h43;
            7'd47: ch = 8'h56;
            7'd48: ch = 8'h42;
            7'd49: ch = 8'h4E;
            7'd50: ch = 8'h4D;
            7'd51: ch = 8'h3C;
            7'd52: ch = 8'h3E;
            7'd53: ch = 8'h3F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd71: ch = 8'h37;
            7'd72: ch = 8'h38;
            7'd73: ch = 8'h39;
            7'd74: ch = 8'h2D;
            7'd75: ch = 8'h34;
            7'd76: ch = 8'h35;
            7'd77: ch = 8'h36;
            7'd78: ch = 8'h2B;
            7'd79: ch = 8'h31;
            7'd80: ch = 8'h32;
            7'd81: ch = 8'h33;
            7'd82: ch = 8'h30;
            7'd83: ch = 8'h2E;
            default: ch = CHAR_UNDEF;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/kbd_dec_xlate.sv
// Modifier tracking and scan code translation.
// Depends on kbd_dec_pkg for scan code constants and lookup tables.
module kbd_dec_xlate (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [7:0]            scan_byte,
    output kbd_dec_pkg::kbd_key_t key
);

    logic       shift_reg;
    logic       shift_next;
    logic       ctrl_reg;
    logic       ctrl_next;
    logic       is_mod;
    logic [7:0] raw_ch;

    always_comb begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        is_mod     = 1'b1;
        priority if (scan_byte == kbd_dec_pkg::SC_LSHIFT_MAKE ||
                     scan_byte == kbd_dec_pkg::SC_RSHIFT_MAKE) begin
            shift_next = 1'b1;
        end else if (scan_byte == kbd_dec_pkg::SC_LSHIFT_BREAK ||
                     scan_byte == kbd_dec_pkg::SC_RSHIFT_BREAK) begin
            shift_next = 1'b0;
        end else if (scan_byte == kbd_dec_pkg::SC_LCTRL_MAKE) begin
            ctrl_next = 1'b1;
        end else if (scan_byte == kbd_dec_pkg::SC_LCTRL_BREAK) begin
            ctrl_next = 1'b0;
        end else begin
            is_mod = 1'b0;
        end
    end

    assign raw_ch = shift_reg ? kbd_dec_pkg::upper_map(scan_byte[6:0])
                              : kbd_dec_pkg::plain_map(scan_byte[6:0]);

    // Drop modifiers, other releases and undefined codes.
    assign key.hit = !is_mod && !scan_byte[kbd_dec_pkg::SC_BREAK_BIT] &&
                     (raw_ch != kbd_dec_pkg::CHAR_UNDEF);
    assign key.ch  = ctrl_reg ? (raw_ch & kbd_dec_pkg::CHAR_CTRL_BITS) : raw_ch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
        end else if (en) begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

>>> hw/rtl/kbd_dec_queue.sv
// Character ring queue: storage array, slot pointers and fill count.
// Depends on kbd_dec_pkg for geometry and request/status structs.
module kbd_dec_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kbd_dec_pkg::kbd_q_req_t  req,
    output kbd_dec_pkg::kbd_q_stat_t stat,
    output logic [7:0]               rd_data
);

    localparam int SLOT_W = kbd_dec_pkg::SLOT_W;
    localparam int FILL_W = (SLOT_W > kbd_dec_pkg::FILL_OUT_W) ?
                            SLOT_W : kbd_dec_pkg::FILL_OUT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(kbd_dec_pkg::QUEUE_SLOTS - 1);

    logic [7:0]        mem [kbd_dec_pkg::QUEUE_SLOTS];
    logic [7:0]        rd_data_reg;
    logic [SLOT_W-1:0] wr_reg;
    logic [SLOT_W-1:0] wr_next;
    logic [SLOT_W-1:0] rd_reg;
    logic [SLOT_W-1:0] rd_next;
    logic [SLOT_W-1:0] count_reg;
    logic [SLOT_W-1:0] count_next;
    logic [FILL_W-1:0] fill_wide;
    logic              full;
    logic              empty;
    logic              push_ok;
    logic              pop_ok;

    assign full    = (count_reg == LAST_SLOT);
    assign empty   = (count_reg == '0);
    assign push_ok = req.push && !full;
    assign pop_ok  = req.pop && !empty;

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push_ok) begin
            wr_next    = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_next    = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_reg] <= req.push_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ok) begin
            rd_data_reg <= mem[rd_reg];
        end
    end

    assign fill_wide      = FILL_W'(count_next);
    assign stat.full      = full;
    assign stat.empty     = empty;
    assign stat.fill_next = fill_wide[kbd_dec_pkg::FILL_OUT_W-1:0];
    assign rd_data        = rd_data_reg;

endmodule

>>> hw/rtl/keyboard_scancode_decoder_fifo.sv
// Set 1 keyboard scan code decoder with a character queue.
// Depends on kbd_dec_pkg, kbd_dec_xlate, kbd_dec_queue and assert_macros.svh.
//
// Each item is either a raw scan code byte or a pop request, and gives exactly one result.
// A byte updates shift (either shift key) and left control, or is translated through the
// unshifted or shifted table; a translated character is reported, masked to five bits
// while control is held, and pushed into a queue of QUEUE_SLOTS-1 characters (dropped and
// flagged when full). A pop returns the oldest character or reports empty. Every result
// carries the fill after the item. Throughput is one item per clock while results are taken.
// From input acceptance to result valid, the item sits in an input register,
// passes the table lookup and pointer update, and lands in the result register while the
// queue memory's single read port registers the popped character alongside it. A held
// result still lets an empty input register take one item; a further item waits until
// the held result is taken. The queue needs no clearing after reset; its entries are
// only read after being written.
module keyboard_scancode_decoder_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kbd_dec_pkg::kbd_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kbd_dec_pkg::kbd_out_t m_data
);

`include "assert_macros.svh"

    logic                     in_valid_reg;
    kbd_dec_pkg::kbd_in_t     in_item_reg;
    logic                     out_valid_reg;
    kbd_dec_pkg::kbd_out_t    out_res_reg;
    kbd_dec_pkg::kbd_out_t    res_next;
    logic                     advance;
    logic                     is_scan;
    kbd_dec_pkg::kbd_key_t    key;
    kbd_dec_pkg::kbd_q_req_t  q_req;
    kbd_dec_pkg::kbd_q_stat_t q_stat;
    logic [7:0]               q_rd_data;

    // Advance the held item into the result register when that slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign is_scan = (in_item_reg.opcode == kbd_dec_pkg::OP_SCAN);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Modifier state and table lookup; modifiers only move on an advancing scan item.
    kbd_dec_xlate u_xlate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance && is_scan),
        .scan_byte (in_item_reg.scan_byte),
        .key       (key)
    );

    // Push translated characters, pop on pop items; the queue itself handles full/empty.
    always_comb begin
        q_req.push      = advance && is_scan && key.hit;
        q_req.push_char = key.ch;
        q_req.pop       = advance && !is_scan;
    end

    kbd_dec_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    // Build the result; the popped character arrives from the memory read register.
    always_comb begin
        res_next             = '0;
        res_next.queue_count = q_stat.fill_next;
        if (is_scan) begin
            if (key.hit) begin
                res_next.key_valid   = 1'b1;
                res_next.key_char    = key.ch;
                res_next.key_dropped = q_stat.full;
            end
        end else begin
            res_next.pop_valid = !q_stat.empty;
        end
    end

    // Result register: hold until taken, refill on advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    always_comb begin
        m_data = out_res_reg;
        if (out_res_reg.pop_valid) begin
            m_data.pop_char = q_rd_data;
        end
    end

    assign m_valid = out_valid_reg;

    // A result reports either a key or a pop, never both.
    `KBD_ASSERT_ALWAYS(a_key_pop_exclusive, !(m_valid && m_data.key_valid && m_data.pop_valid))
    // A dropped character is still a reported character.
    `KBD_ASSERT_ALWAYS(a_drop_has_key, !(m_valid && m_data.key_dropped && !m_data.key_valid))
    // The queue cannot be full and empty at once.
    `KBD_ASSERT_ALWAYS(a_queue_status, !(q_stat.full && q_stat.empty))
    // A pop on a non-empty queue shows up as a returned character in the next result.
    `KBD_ASSERT_NEXT(a_pop_reported, q_req.pop && !q_stat.empty, m_valid && m_data.pop_valid)

endmodule
